[hdl/efr_pkg.sv]
package efr_pkg;

    // common word type for all 32-bit payload values
    typedef logic signed [31:0] word_t;

    // function codes carried on tuser
    localparam logic [2:0] FN_SET  = 3'd0;
    localparam logic [2:0] FN_B2E  = 3'd1;
    localparam logic [2:0] FN_E2B  = 3'd2;
    localparam logic [2:0] FN_RB2E = 3'd3;
    localparam logic [2:0] FN_RE2B = 3'd4;

    // fixed point formats
    localparam int RATE_FRAC = 24;
    localparam int ROT_FRAC  = 30;
    localparam int RATE_SH   = ROT_FRAC - RATE_FRAC;
    localparam logic signed [33:0] RATE_RND = 34'sd1 <<< (RATE_SH - 1);
    localparam word_t RATE_ONE = 32'sd1 <<< RATE_FRAC;
    localparam word_t S32_MAX  = 32'sh7fff_ffff;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< ROT_FRAC;

    // angle constants, Q.32
    localparam longint PI_Q32         = 64'sd13493037705;
    localparam longint TWO_PI_Q32     = 2 * PI_Q32;
    localparam longint HALF_PI_Q32    = PI_Q32 / 2;
    localparam longint QUARTER_PI_Q32 = PI_Q32 / 4;

    // residual angle register width and its constants
    localparam int R_W = 36;
    localparam logic signed [R_W-1:0] PI_R      = R_W'(PI_Q32);
    localparam logic signed [R_W-1:0] TWO_PI_R  = R_W'(TWO_PI_Q32);
    localparam logic signed [R_W-1:0] HALF_PI_R = R_W'(HALF_PI_Q32);

    // arctangent table geometry
    localparam int ATAN_N = 31;
    localparam int ATAN_W = 36;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE, ST_TRIG, ST_MUL, ST_MAT, ST_DIV, ST_XFORM, ST_OUT
    } state_t;

    // cordic lane phases
    typedef enum logic [2:0] {
        CP_IDLE, CP_REDUCE, CP_WRAP0, CP_WRAP1, CP_FOLD, CP_ITER, CP_DONE
    } cordic_ph_t;

    // divider lane phases
    typedef enum logic [1:0] {
        DV_IDLE, DV_RUN, DV_FIX
    } div_ph_t;

    // dot lane control
    typedef struct packed {
        logic start;
        logic rate;
    } dot_ctl_t;

    // divider lane status
    typedef struct packed {
        logic busy;
        logic sat;
    } div_stat_t;

    // clamp to [-1.0, 1.0] in Q2.30
    function automatic word_t clamp_q30(input logic signed [33:0] v);
        if (v > ONE_Q30)
            return word_t'(ONE_Q30);
        else if (v < -ONE_Q30)
            return word_t'(-ONE_Q30);
        else
            return v[31:0];
    endfunction

    // unsigned shift and subtract quotient, elaboration only
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // arctan(2^-i) in Q.32 from the alternating series, elaboration only
    function automatic longint atan_q32(input int i);
        longint sum;
        longint term;
        int     e;
        sum = 0;
        if (i == 0)
            return QUARTER_PI_Q32;
        for (int k = 0; k < 64; k++)
        begin
            e = 62 - i * (2 * k + 1);
            if (e < 0)
                break;
            term = longint'(udiv64(64'd1 << e, 64'(2 * k + 1)));
            sum  = k[0] ? sum - term : sum + term;
        end
        return (sum + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // packed arctangent table
    function automatic logic [ATAN_N*ATAN_W-1:0] atan_table();
        logic [ATAN_N*ATAN_W-1:0] t;
        t = '0;
        for (int i = 0; i < ATAN_N; i++)
        begin
            t[i*ATAN_W +: ATAN_W] = ATAN_W'(atan_q32(i));
        end
        return t;
    endfunction

    // integer square root, elaboration only
    function automatic longint unsigned isqrt64(input longint unsigned n);
        longint unsigned res;
        longint unsigned rem;
        longint unsigned bit_v;
        res   = 0;
        rem   = n;
        bit_v = 64'd1 << 62;
        while (bit_v > rem)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
                res = res >> 1;
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // cordic gain in Q2.30 for a given step count
    function automatic longint cordic_gain(input int iters);
        longint unsigned k2;
        k2 = 64'd1 << 60;
        for (int i = 0; i < iters && i < 31; i++)
        begin
            k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
        end
        return longint'(isqrt64(k2));
    endfunction

endpackage

[hdl/efr_cordic_lane.sv]
module efr_cordic_lane #(
    parameter int FRAC_BITS       = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  efr_pkg::word_t angle,
    output logic          busy,
    output efr_pkg::word_t cos_val,
    output efr_pkg::word_t sin_val
);
    import efr_pkg::*;

    localparam int MW        = 64 - FRAC_BITS;
    localparam int RED_STEPS = 29 - FRAC_BITS;
    localparam int RCW       = $clog2(RED_STEPS);
    localparam int ITW       = $clog2(TRIG_ITERATIONS);
    localparam logic [RCW-1:0] RED_LAST = RCW'(RED_STEPS - 1);
    localparam logic [ITW-1:0] IT_LAST  = ITW'(TRIG_ITERATIONS - 1);
    localparam logic signed [33:0] GAIN = 34'(cordic_gain(TRIG_ITERATIONS));
    localparam logic [ATAN_N*ATAN_W-1:0] ATAN_TAB = atan_table();
    localparam logic [MW-1:0] TWO_PI_M = MW'(TWO_PI_Q32);

    cordic_ph_t state_reg, state_next;
    logic [MW-1:0]           mag_reg;
    logic                    neg_reg;
    logic [RCW-1:0]          cnt_reg;
    logic [ITW-1:0]          it_reg;
    logic signed [R_W-1:0]   r_reg;
    logic signed [33:0]      x_reg, y_reg;

    logic signed [MW-1:0]    scaled;
    logic [MW-1:0]           red_sub;
    logic signed [ATAN_W-1:0] atan_v;
    logic signed [33:0]      dx, dy;
    word_t                   x_cl;

    // angle scaled to Q.32 and per-step operands
    assign scaled  = MW'(angle) <<< (32 - FRAC_BITS);
    assign red_sub = TWO_PI_M << cnt_reg;
    assign atan_v  = ATAN_TAB[it_reg*ATAN_W +: ATAN_W];
    assign dx      = y_reg >>> it_reg;
    assign dy      = x_reg >>> it_reg;
    assign x_cl    = clamp_q30(x_reg);

    // phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CP_IDLE;
        else
            state_reg <= state_next;
    end

    // next phase
    always_comb
    begin
        state_next = state_reg;
        busy       = (state_reg != CP_IDLE);
        unique case (state_reg)
            CP_IDLE:   if (start) state_next = CP_REDUCE;
            CP_REDUCE: if (cnt_reg == '0) state_next = CP_WRAP0;
            CP_WRAP0:  state_next = CP_WRAP1;
            CP_WRAP1:  state_next = CP_FOLD;
            CP_FOLD:   state_next = CP_ITER;
            CP_ITER:   if (it_reg == IT_LAST) state_next = CP_DONE;
            CP_DONE:   state_next = CP_IDLE;
            default:   state_next = CP_IDLE;
        endcase
    end

    // reduction, fold and rotation datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            CP_IDLE:
                if (start)
                begin
                    mag_reg <= scaled[MW-1] ? MW'(-scaled) : MW'(scaled);
                    neg_reg <= scaled[MW-1];
                    cnt_reg <= RED_LAST;
                end
            CP_REDUCE:
            begin
                if (mag_reg >= red_sub)
                    mag_reg <= mag_reg - red_sub;
                cnt_reg <= cnt_reg - 1'b1;
            end
            CP_WRAP0:
                if (neg_reg && mag_reg != '0)
                    r_reg <= TWO_PI_R - R_W'(mag_reg);
                else
                    r_reg <= R_W'(mag_reg);
            CP_WRAP1:
                if (r_reg >= PI_R)
                    r_reg <= r_reg - TWO_PI_R;
            CP_FOLD:
            begin
                if (r_reg > HALF_PI_R)
                begin
                    r_reg   <= PI_R - r_reg;
                    neg_reg <= 1'b1;
                end
                else if (r_reg < -HALF_PI_R)
                begin
                    r_reg   <= -PI_R - r_reg;
                    neg_reg <= 1'b1;
                end
                else
                    neg_reg <= 1'b0;
                x_reg  <= GAIN;
                y_reg  <= '0;
                it_reg <= '0;
            end
            CP_ITER:
            begin
                if (r_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    r_reg <= r_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    r_reg <= r_reg + atan_v;
                end
                it_reg <= it_reg + 1'b1;
            end
            CP_DONE:
            begin
                cos_val <= neg_reg ? -x_cl : x_cl;
                sin_val <= clamp_q30(y_reg);
            end
            default: ;
        endcase
    end

endmodule

[hdl/efr_div_lane.sv]
module efr_div_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  efr_pkg::word_t      num,
    input  efr_pkg::word_t      den,
    output efr_pkg::div_stat_t  stat,
    output efr_pkg::word_t      quo
);
    import efr_pkg::*;

    div_ph_t state_reg, state_next;
    logic [31:0] rem_reg;
    logic [30:0] sh_reg;
    logic [30:0] q_reg;
    logic [31:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic        sat_reg;

    logic [31:0] anum, aden;
    logic        sat_now, neg_now;
    logic [32:0] rem2;
    logic        qbit;
    logic [32:0] rem_sub;

    // magnitudes and early saturation check
    assign anum    = num[31] ? 32'(-num) : 32'(num);
    assign aden    = den[31] ? 32'(-den) : 32'(den);
    assign sat_now = ({7'd0, anum} >= {aden, 7'd0});
    assign neg_now = num[31] ^ den[31];

    // one restoring step
    assign rem2    = {rem_reg, sh_reg[30]};
    assign qbit    = (rem2 >= {1'b0, d_reg});
    assign rem_sub = qbit ? rem2 - {1'b0, d_reg} : rem2;

    // phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DV_IDLE;
        else
            state_reg <= state_next;
    end

    // next phase
    always_comb
    begin
        state_next = state_reg;
        stat.busy  = (state_reg != DV_IDLE);
        stat.sat   = sat_reg;
        unique case (state_reg)
            DV_IDLE: if (start && !sat_now) state_next = DV_RUN;
            DV_RUN:  if (cnt_reg == '0) state_next = DV_FIX;
            DV_FIX:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    // quotient datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
                if (start)
                begin
                    sat_reg <= sat_now;
                    neg_reg <= neg_now;
                    d_reg   <= aden;
                    rem_reg <= {7'd0, anum[31:7]};
                    sh_reg  <= {anum[6:0], 24'd0};
                    q_reg   <= '0;
                    cnt_reg <= 5'd30;
                    if (sat_now)
                    begin
                        if (anum == '0)
                            quo <= '0;
                        else
                            quo <= neg_now ? -S32_MAX : S32_MAX;
                    end
                end
            DV_RUN:
            begin
                rem_reg <= rem_sub[31:0];
                sh_reg  <= {sh_reg[29:0], 1'b0};
                q_reg   <= {q_reg[29:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
            end
            DV_FIX:
                quo <= neg_reg ? -word_t'({1'b0, q_reg}) : word_t'({1'b0, q_reg});
            default: ;
        endcase
    end

endmodule

[hdl/efr_dot_lane.sv]
module efr_dot_lane (
    input  logic              clk,
    input  logic              rst_n,
    input  efr_pkg::dot_ctl_t  ctl,
    input  efr_pkg::word_t     vec [3],
    input  efr_pkg::word_t     elem [3],
    output logic              busy,
    output efr_pkg::word_t     res
);
    import efr_pkg::*;

    logic               busy_reg;
    logic [2:0]         cnt_reg;
    logic               rate_reg;
    logic signed [63:0] prod_reg;
    logic signed [41:0] acc_reg;

    word_t              mul_a, mul_b;
    logic signed [63:0] rnd_sum;
    logic signed [39:0] term;

    assign busy = busy_reg;

    // operand pick for this step
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin mul_a = vec[0]; mul_b = elem[0]; end
            3'd1:    begin mul_a = vec[1]; mul_b = elem[1]; end
            3'd2:    begin mul_a = vec[2]; mul_b = elem[2]; end
            default: begin mul_a = '0;     mul_b = '0;      end
        endcase
    end

    // round one product to the output format
    assign rnd_sum = prod_reg + (rate_reg ? (64'sd1 <<< (RATE_FRAC - 1))
                                          : (64'sd1 <<< (ROT_FRAC - 1)));
    assign term    = rate_reg ? 40'(rnd_sum >>> RATE_FRAC) : 40'(rnd_sum >>> ROT_FRAC);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (!busy_reg)
        begin
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
        else
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 3'd4)
                busy_reg <= 1'b0;
        end
    end

    // multiply, accumulate, saturate
    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (ctl.start)
            begin
                rate_reg <= ctl.rate;
                acc_reg  <= '0;
            end
        end
        else
        begin
            if (cnt_reg < 3'd3)
                prod_reg <= mul_a * mul_b;
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd3)
                acc_reg <= acc_reg + 42'(term);
            if (cnt_reg == 3'd4)
            begin
                if (acc_reg > 42'(S32_MAX))
                    res <= S32_MAX;
                else if (acc_reg < -42'sd2147483648)
                    res <= 32'sh8000_0000;
                else
                    res <= acc_reg[31:0];
            end
        end
    end

endmodule

[hdl/euler_attitude_frame_rotator.sv]
// Vector and rate transforms run the three row lanes between accept and result,
//   unused function codes go straight to the output, and set angles run the
//   cordic lanes, 14 shared products, then the divider lanes;
//   the divider lanes do not run when every one of them saturates
// throughput: one word in flight; the next word is accepted once the result is registered
// reset: asynchronous active low, clears matrices, trig values, flag and all handshakes
module euler_attitude_frame_rotator #(
    parameter int FRAC_BITS       = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // in_a, in_b, in_c
    input  logic [2:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // out_x, out_y, out_z, cos_roll_out, cos_pitch_out,
                                    // cos_yaw_out, sin_roll_out, sin_pitch_out, sin_yaw_out
    output logic [0:0]   m_tuser    // gimbal_saturated
);
    import efr_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'd13;

    state_t state_reg, state_next;

    // stored attitude state
    word_t rot_reg  [9];
    word_t rate_reg [9];
    word_t trig_reg [6];
    logic  flag_reg;

    // working registers
    logic [2:0]         func_reg;
    word_t              vec_reg [3];
    logic [3:0]         step_reg;
    logic               phase_reg;
    logic signed [63:0] prod_reg;
    word_t              pq_reg [14];
    word_t              res_reg [3];
    logic [287:0]       m_data_reg;
    logic               m_flag_reg;
    logic               m_valid_reg;

    logic in_acc, trig_start, dot_start_c, div_start, out_load;
    logic transpose, rate_sel;
    word_t mul_a, mul_b;
    logic signed [63:0] mul_sum;
    word_t cr, cp, cy, sr, sp, sy;

    logic  [2:0] trig_busy;
    word_t       lane_cos [3];
    word_t       lane_sin [3];
    dot_ctl_t    dot_ctl;
    logic  [2:0] dot_busy;
    word_t       dot_res [3];
    word_t       div_num [4];
    word_t       div_den [4];
    div_stat_t   div_stat [4];
    word_t       div_quo [4];
    logic        div_busy_any, div_sat_any;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flag_reg;

    assign cr = trig_reg[0];
    assign cp = trig_reg[1];
    assign cy = trig_reg[2];
    assign sr = trig_reg[3];
    assign sp = trig_reg[4];
    assign sy = trig_reg[5];

    assign transpose = (func_reg == FN_E2B) || (func_reg == FN_RE2B);
    assign rate_sel  = (func_reg == FN_RB2E) || (func_reg == FN_RE2B);

    // sine and cosine lanes: roll, pitch, yaw
    for (genvar a = 0; a < 3; a++)
    begin : g_trig
        efr_cordic_lane #(
            .FRAC_BITS      (FRAC_BITS),
            .TRIG_ITERATIONS(TRIG_ITERATIONS)
        ) u_cordic (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (trig_start),
            .angle  (word_t'(s_tdata[a*32 +: 32])),
            .busy   (trig_busy[a]),
            .cos_val(lane_cos[a]),
            .sin_val(lane_sin[a])
        );
    end

    // row lanes for the vector transforms
    assign dot_ctl.start = dot_start_c;
    assign dot_ctl.rate  = (s_tuser == FN_RB2E) || (s_tuser == FN_RE2B);

    for (genvar j = 0; j < 3; j++)
    begin : g_dot
        word_t elem [3];
        for (genvar k = 0; k < 3; k++)
        begin : g_el
            assign elem[k] = rate_sel
                ? (transpose ? rate_reg[k*3+j] : rate_reg[j*3+k])
                : (transpose ? rot_reg[k*3+j]  : rot_reg[j*3+k]);
        end
        efr_dot_lane u_dot (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (dot_ctl),
            .vec  (vec_reg),
            .elem (elem),
            .busy (dot_busy[j]),
            .res  (dot_res[j])
        );
    end

    // divider lanes for the rate matrix entries divided by cos pitch
    assign div_num[0] = pq_reg[8];
    assign div_num[1] = pq_reg[10];
    assign div_num[2] = sr;
    assign div_num[3] = cr;

    for (genvar d = 0; d < 4; d++)
    begin : g_div
        assign div_den[d] = cp;
        efr_div_lane u_div (
            .clk  (clk),
            .rst_n(rst_n),
            .start(div_start),
            .num  (div_num[d]),
            .den  (div_den[d]),
            .stat (div_stat[d]),
            .quo  (div_quo[d])
        );
    end

    // merge divider status
    always_comb
    begin
        div_busy_any = 1'b0;
        div_sat_any  = 1'b0;
        for (int d = 0; d < 4; d++)
        begin
            div_busy_any = div_busy_any | div_stat[d].busy;
            div_sat_any  = div_sat_any  | div_stat[d].sat;
        end
    end

    // shared multiplier operands for the matrix products
    always_comb
    begin
        case (step_reg)
            4'd0:    begin mul_a = cp;         mul_b = cy; end
            4'd1:    begin mul_a = cy;         mul_b = sr; end
            4'd2:    begin mul_a = pq_reg[1];  mul_b = sp; end
            4'd3:    begin mul_a = cr;         mul_b = sy; end
            4'd4:    begin mul_a = cr;         mul_b = cy; end
            4'd5:    begin mul_a = pq_reg[4];  mul_b = sp; end
            4'd6:    begin mul_a = sr;         mul_b = sy; end
            4'd7:    begin mul_a = cp;         mul_b = sy; end
            4'd8:    begin mul_a = sr;         mul_b = sp; end
            4'd9:    begin mul_a = pq_reg[8];  mul_b = sy; end
            4'd10:   begin mul_a = cr;         mul_b = sp; end
            4'd11:   begin mul_a = pq_reg[10]; mul_b = sy; end
            4'd12:   begin mul_a = cp;         mul_b = sr; end
            4'd13:   begin mul_a = cr;         mul_b = cp; end
            default: begin mul_a = '0;         mul_b = '0; end
        endcase
    end

    assign mul_sum = prod_reg + (64'sd1 <<< (ROT_FRAC - 1));

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer next state and strobes
    always_comb
    begin
        state_next  = state_reg;
        trig_start  = 1'b0;
        dot_start_c = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    case (s_tuser) inside
                        FN_SET:
                        begin
                            trig_start = 1'b1;
                            state_next = ST_TRIG;
                        end
                        FN_B2E, FN_E2B, FN_RB2E, FN_RE2B:
                        begin
                            dot_start_c = 1'b1;
                            state_next  = ST_XFORM;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            ST_TRIG:  if (trig_busy == '0) state_next = ST_MUL;
            ST_MUL:   if (phase_reg && step_reg == LAST_STEP) state_next = ST_MAT;
            ST_MAT:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:   if (!div_busy_any) state_next = ST_OUT;
            ST_XFORM: if (dot_busy == '0) state_next = ST_OUT;
            ST_OUT:
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // stored attitude state, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                rot_reg[i]  <= '0;
                rate_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++)
                trig_reg[i] <= '0;
            flag_reg    <= 1'b0;
            step_reg    <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // capture sines and cosines
            if (state_reg == ST_TRIG && trig_busy == '0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    trig_reg[i]   <= lane_cos[i];
                    trig_reg[i+3] <= lane_sin[i];
                end
                step_reg  <= '0;
                phase_reg <= 1'b0;
            end

            // product steps
            if (state_reg == ST_MUL)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                    step_reg <= step_reg + 1'b1;
            end

            // build rotation matrix and fixed rate entries
            if (state_reg == ST_MAT)
            begin
                rot_reg[0] <= clamp_q30(34'(pq_reg[0]));
                rot_reg[1] <= clamp_q30(34'(pq_reg[2]) - 34'(pq_reg[3]));
                rot_reg[2] <= clamp_q30(34'(pq_reg[5]) + 34'(pq_reg[6]));
                rot_reg[3] <= clamp_q30(34'(pq_reg[7]));
                rot_reg[4] <= clamp_q30(34'(pq_reg[9]) + 34'(pq_reg[4]));
                rot_reg[5] <= clamp_q30(34'(pq_reg[11]) - 34'(pq_reg[1]));
                rot_reg[6] <= clamp_q30(-34'(sp));
                rot_reg[7] <= clamp_q30(34'(pq_reg[12]));
                rot_reg[8] <= clamp_q30(34'(pq_reg[13]));
                rate_reg[0] <= RATE_ONE;
                rate_reg[3] <= '0;
                rate_reg[4] <= 32'((34'(cr) + RATE_RND) >>> RATE_SH);
                rate_reg[5] <= 32'((-34'(sr) + RATE_RND) >>> RATE_SH);
                rate_reg[6] <= '0;
            end

            // divided rate entries and gimbal flag
            if (state_reg == ST_DIV && !div_busy_any)
            begin
                rate_reg[1] <= div_quo[0];
                rate_reg[2] <= div_quo[1];
                rate_reg[7] <= div_quo[2];
                rate_reg[8] <= div_quo[3];
                flag_reg    <= div_sat_any;
            end

            // output word valid
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg   <= s_tuser;
            vec_reg[0] <= s_tdata[31:0];
            vec_reg[1] <= s_tdata[63:32];
            vec_reg[2] <= s_tdata[95:64];
            for (int i = 0; i < 3; i++)
                res_reg[i] <= '0;
        end

        if (state_reg == ST_MUL)
        begin
            if (!phase_reg)
                prod_reg <= mul_a * mul_b;
            else
                pq_reg[step_reg] <= mul_sum[61:30];
        end

        if (state_reg == ST_XFORM && dot_busy == '0)
        begin
            for (int i = 0; i < 3; i++)
                res_reg[i] <= dot_res[i];
        end

        if (out_load)
        begin
            m_data_reg <= {trig_reg[5], trig_reg[4], trig_reg[3],
                           trig_reg[2], trig_reg[1], trig_reg[0],
                           res_reg[2], res_reg[1], res_reg[0]};
            m_flag_reg <= flag_reg;
        end
    end

endmodule

[hdl/efr_checker.sv]
module efr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [287:0] m_tdata
);

    // one word in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reported cosine of roll stays within unit range
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[127:96]) <= 32'sd1073741824) &&
                     ($signed(m_tdata[127:96]) >= -32'sd1073741824))
        else $error("cosine out of range");

endmodule

bind euler_attitude_frame_rotator efr_checker u_efr_checker (.*);
